### hdl/assert_macros.svh
// Assertion macros for the peak-brightness ramp RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PBL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define PBL_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pbl_pkg.sv
// Types, codes and the level ROM of the peak-brightness ramp.
package pbl_pkg;

	localparam int LEVEL_COUNT_DEF = 31;
	localparam int LEVEL_W_MAX     = 6;
	localparam int ROM_DEPTH       = 31;

	localparam logic [15:0] INTERVAL_RESET = 16'd1000;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_REQ    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_ENABLE = 2'd3;

	localparam logic RES_LEVEL  = 1'b0;
	localparam logic RES_STATUS = 1'b1;

	localparam logic [7:0] REQ_ALLOWED = 8'h11;
	localparam logic [7:0] STATUS_DONE = 8'h04;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] request_byte;
		logic       enable_value;
		logic       panel_ready;
		logic       recovery_pending;
		logic       super_bright_mode;
	} pbl_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [4:0]  level;
		logic [15:0] delta_y_max_word;
		logic [15:0] gray_voltage_word;
		logic [7:0]  status_byte;
	} pbl_result_t;

	// {delta_y_max, gray_voltage} per level
	localparam logic [31:0] LEVEL_ROM [ROM_DEPTH] = '{
		{16'h19, 16'h110}, {16'h1A, 16'h10D}, {16'h1B, 16'h10B}, {16'h1C, 16'h109},
		{16'h1E, 16'h107}, {16'h1F, 16'h105}, {16'h20, 16'h103}, {16'h22, 16'h101},
		{16'h23, 16'h0FF}, {16'h24, 16'h0FD}, {16'h26, 16'h0FB}, {16'h27, 16'h0F8},
		{16'h28, 16'h0F6}, {16'h29, 16'h0F4}, {16'h2B, 16'h0F2}, {16'h2C, 16'h0F0},
		{16'h2D, 16'h0EE}, {16'h2F, 16'h0EC}, {16'h30, 16'h0EA}, {16'h31, 16'h0E8},
		{16'h33, 16'h0E6}, {16'h34, 16'h0E3}, {16'h35, 16'h0E1}, {16'h36, 16'h0DF},
		{16'h38, 16'h0DD}, {16'h39, 16'h0DB}, {16'h3A, 16'h0D9}, {16'h3C, 16'h0D7},
		{16'h3D, 16'h0D5}, {16'h3E, 16'h0D3}, {16'h40, 16'h0D1}
	};

	// Saturate levels past the table at its last entry.
	function automatic logic [31:0] rom_lookup(input logic [LEVEL_W_MAX-1:0] lvl);
		logic [4:0] idx;
		idx = (lvl >= LEVEL_W_MAX'(ROM_DEPTH)) ? 5'(ROM_DEPTH - 1) : lvl[4:0];
		return LEVEL_ROM[idx];
	endfunction

endpackage

### hdl/peak_brightness_level_ramp.sv
// Top level of the peak-brightness level ramp.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall               | into      | kind, request_byte, flags
//  out     | out_valid, out_stall             | out of    | result_kind, level, words,
//          |                                  |           | status_byte
//  cfg     | cfg_valid, cfg_ready, cfg_data   | into      | step interval in ticks
//
// Each input word is held in the input register, is evaluated there by the
// state update logic, and any result lands in the result register when the word
// commits: one word per cycle sustained while the output does not stall.
// Reset (arst_n low) clears the level, target, last request byte, schedule and
// enable, and sets the step interval to 1000 ticks. A stalled result only holds
// the input register when the word there would produce a result; other words drain.
// The configuration port is always ready.
module peak_brightness_level_ramp
	import pbl_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  request_byte,
	input  logic        enable_value,
	input  logic        panel_ready,
	input  logic        recovery_pending,
	input  logic        super_bright_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [4:0]  level,
	output logic [15:0] delta_y_max_word,
	output logic [15:0] gray_voltage_word,
	output logic [7:0]  status_byte
);

	pbl_item_t   in_item, item_s1;
	pbl_result_t res, res_q;
	logic        valid_s1, advance, res_valid, out_free;

	// Configuration must only be written while idle (the user's duty; the block does not enforce it), so take it at once.
	assign cfg_ready = 1'b1;

	assign in_item = '{
		kind:              kind,
		request_byte:      request_byte,
		enable_value:      enable_value,
		panel_ready:       panel_ready,
		recovery_pending:  recovery_pending,
		super_bright_mode: super_bright_mode
	};

	// Hold the input word while its result cannot move into the output register.
	pbl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.advance  (advance),
		.stall_up (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Evaluate the held word against the level state; advance commits it.
	pbl_core #(
		.LEVEL_COUNT (LEVEL_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	// Capture a result word only when the held word commits.
	pbl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign result_kind       = res_q.result_kind;
	assign level             = res_q.level;
	assign delta_y_max_word  = res_q.delta_y_max_word;
	assign gray_voltage_word = res_q.gray_voltage_word;
	assign status_byte       = res_q.status_byte;

endmodule

### hdl/pbl_in_stage.sv
// Input register of the peak-brightness ramp.
module pbl_in_stage
	import pbl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  pbl_item_t in_item,
	input  logic      advance,
	output logic      stall_up,
	output logic      valid_s1,
	output pbl_item_t item_s1
);

	logic load;

	assign stall_up = valid_s1 && !advance;
	assign load     = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hdl/pbl_core.sv
// Level state, ramp schedule and the per-word update logic.
module pbl_core
	import pbl_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        valid_s1,
	input  pbl_item_t   item_s1,
	input  logic        out_free,
	output logic        advance,
	output logic        res_valid,
	output pbl_result_t res
);
	`include "assert_macros.svh"

	localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam logic [LW-1:0] TOP = LW'(LEVEL_COUNT - 1);

	logic [15:0]   interval_q;
	logic [LW-1:0] cur_q, cur_n;
	logic [LW-1:0] tgt_q, tgt_n;
	logic [7:0]    last_q, last_n;
	logic          fe_q, fe_n;
	logic          pend_q, pend_n;
	logic [15:0]   ticks_q, ticks_n;

	logic          gate, req_ok, do_step, lvl_write;
	logic [LW-1:0] req_tgt, step_tgt, stepped;
	logic [15:0]   ivl_eff;
	logic [31:0]   rom_word;

	function automatic logic [4:0] rom_level(input logic [LW-1:0] lvl);
		logic [LEVEL_W_MAX-1:0] wide;
		wide = LEVEL_W_MAX'(lvl);
		return wide[4:0];
	endfunction

	assign gate = item_s1.panel_ready && !item_s1.recovery_pending && fe_q
		&& item_s1.super_bright_mode;
	assign req_ok   = (item_s1.request_byte & ~REQ_ALLOWED) == 8'h00;
	assign req_tgt  = item_s1.request_byte[4] ? TOP : '0;
	assign step_tgt = (item_s1.kind == KIND_REQ) ? req_tgt : tgt_q;
	assign stepped  = (cur_q > step_tgt) ? cur_q - 1'b1 : cur_q + 1'b1;
	assign ivl_eff  = (interval_q == 16'd0) ? 16'd1 : interval_q;

	always_comb begin
		cur_n     = cur_q;
		tgt_n     = tgt_q;
		last_n    = last_q;
		fe_n      = fe_q;
		pend_n    = pend_q;
		ticks_n   = ticks_q;
		do_step   = 1'b0;
		lvl_write = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		rom_word  = '0;
		case (item_s1.kind)
			KIND_TICK: begin
				if (pend_q) begin
					if (ticks_q > 16'd1) begin
						ticks_n = ticks_q - 16'd1;
					end else begin
						ticks_n = '0;
						pend_n  = 1'b0;
						do_step = (cur_q != tgt_q) && gate;
					end
				end
			end
			KIND_REQ: begin
				if (req_ok && gate) begin
					tgt_n  = req_tgt;
					last_n = item_s1.request_byte;
					if (cur_q != req_tgt) begin
						pend_n  = 1'b0;
						ticks_n = '0;
						if (item_s1.request_byte[0]) begin
							do_step = 1'b1;
						end else begin
							cur_n     = req_tgt;
							lvl_write = 1'b1;
						end
					end
				end
			end
			KIND_STATUS: begin
				res_valid       = 1'b1;
				res.result_kind = RES_STATUS;
				res.status_byte = last_q | ((cur_q == tgt_q) ? STATUS_DONE : 8'h00);
			end
			KIND_ENABLE: begin
				if (item_s1.enable_value != fe_q) begin
					fe_n    = item_s1.enable_value;
					cur_n   = '0;
					tgt_n   = '0;
					pend_n  = 1'b0;
					ticks_n = '0;
				end
			end
			default: ;
		endcase
		// One step toward the target, then schedule the next unless the target is reached.
		if (do_step) begin
			cur_n     = stepped;
			pend_n    = stepped != step_tgt;
			ticks_n   = (stepped != step_tgt) ? ivl_eff : 16'd0;
			lvl_write = 1'b1;
		end
		if (lvl_write) begin
			rom_word              = rom_lookup(LEVEL_W_MAX'(cur_n));
			res_valid             = 1'b1;
			res.result_kind       = RES_LEVEL;
			res.level             = rom_level(cur_n);
			res.delta_y_max_word  = rom_word[31:16];
			res.gray_voltage_word = rom_word[15:0];
		end
	end

	assign advance  = valid_s1 && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			tgt_q   <= '0;
			last_q  <= '0;
			fe_q    <= 1'b0;
			pend_q  <= 1'b0;
			ticks_q <= '0;
		end else if (advance) begin
			cur_q   <= cur_n;
			tgt_q   <= tgt_n;
			last_q  <= last_n;
			fe_q    <= fe_n;
			pend_q  <= pend_n;
			ticks_q <= ticks_n;
		end
	end

	`PBL_ASSERT(a_level_range, cur_q <= TOP, "level beyond top")
	`PBL_ASSERT(a_target_ends, (tgt_q == TOP) || (tgt_q == '0), "target not an end level")
	`PBL_ASSERT(a_pend_ticks, pend_q == (ticks_q != 16'd0), "schedule and count disagree")
	`PBL_ASSERT_NEXT(a_enable_clear,
		advance && item_s1.kind == KIND_ENABLE && item_s1.enable_value != fe_q,
		cur_q == '0 && tgt_q == '0 && !pend_q, "enable change did not clear level")

endmodule

### hdl/pbl_out_stage.sv
// Result register of the peak-brightness ramp.
module pbl_out_stage
	import pbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  pbl_result_t res,
	input  logic        out_stall,
	output logic        out_free,
	output logic        out_valid,
	output pbl_result_t res_q
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take && out_free) begin
			res_q <= res;
		end
	end

endmodule
